@@ design/assert_macros.svh @@
// Assertion shorthands for the parser checker.
// Each expects signals named clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while in reset
`define CHK_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("parser check failed");

// Next-cycle implication, off while in reset
`define CHK_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("parser check failed");

// Next-cycle implication that also covers the reset cycle
`define CHK_RST(lbl, pre, post) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("parser check failed");

`endif

@@ design/ttip_pkg.sv @@
`default_nettype none

package ttip_pkg;

  // Field widths
  localparam int unsigned CH_W    = 8;
  localparam int unsigned RADIX_W = 6;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned VAL_W   = 32;

  // Characters consumed before a result is forced
  localparam int unsigned MAX_CHARS = 31;
  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_CHARS);

  // Character codes
  localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_W-1:0] CH_UA    = 8'h41;
  localparam logic [CH_W-1:0] CH_UX    = 8'h58;
  localparam logic [CH_W-1:0] CH_UZ    = 8'h5A;
  localparam logic [CH_W-1:0] CH_LA    = 8'h61;
  localparam logic [CH_W-1:0] CH_LX    = 8'h78;
  localparam logic [CH_W-1:0] CH_LZ    = 8'h7A;
  localparam logic [CH_W-1:0] LETTER_OFS = 8'd10;

  // Bases
  localparam logic [RADIX_W-1:0] BASE_AUTO = 6'd0;
  localparam logic [RADIX_W-1:0] BASE_ONE  = 6'd1;
  localparam logic [RADIX_W-1:0] BASE_OCT  = 6'd8;
  localparam logic [RADIX_W-1:0] BASE_DEC  = 6'd10;
  localparam logic [RADIX_W-1:0] BASE_HEX  = 6'd16;
  localparam logic [RADIX_W-1:0] BASE_MAX  = 6'd36;

  // Sign codes
  localparam logic [1:0] SIGN_NONE  = 2'd0;
  localparam logic [1:0] SIGN_PLUS  = 2'd1;
  localparam logic [1:0] SIGN_MINUS = 2'd2;

  // Classified input item, front to back
  typedef struct packed {
    logic               first;
    logic [RADIX_W-1:0] radix;
    logic               bad_base;
    logic               nul;
    logic               space;
    logic               sign;
    logic               minus;
    logic               zero;
    logic               is_x;
    logic               dec;
    logic               has_dig;
    logic [RADIX_W-1:0] dig;
  } item_t;

  // Result before the final negate, back to result queue
  typedef struct packed {
    logic [VAL_W-1:0] mag;
    logic             neg;
    logic [POS_W-1:0] end_index;
    logic             bad_base;
  } result_t;

endpackage

`default_nettype wire

@@ design/text_to_integer_parser_top.sv @@
// Channel   Direction  Handshake          Transfer when     Payload
// input     in         push / full        push && !full     ch, first, radix
// result    out        empty / pop        pop && !empty     value, end_index, bad_base
//
// One character per cycle sustained while the result queue has room; the parser
// does one multiply-add by the base per character, which sets the cycle.
// A result reaches the result ports at the earliest once its character is in the
// input queue and the parser has then written the result into the result queue.
// Synchronous reset empties both two-entry queues and clears the parse state.
// full rises with two characters queued; the parser stalls on two waiting results.
`default_nettype none

module text_to_integer_parser_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic        [ttip_pkg::CH_W-1:0]   ch,
  input  logic                               first,
  input  logic        [ttip_pkg::RADIX_W-1:0] radix,
  input  logic                               push,
  output logic                               full,
  output logic signed [ttip_pkg::VAL_W-1:0]  value,
  output logic        [ttip_pkg::POS_W-1:0]  end_index,
  output logic                               bad_base,
  output logic                               empty,
  input  logic                               pop
);

  ttip_pkg::item_t    item;
  logic               item_empty;
  logic               item_pop;
  ttip_pkg::result_t  res;
  logic               res_push;
  logic               res_full;

  // Classify and queue characters
  ttip_front u_front (
    .clk   (clk),
    .rst   (rst),
    .ch    (ch),
    .first (first),
    .radix (radix),
    .push  (push),
    .full  (full),
    .item  (item),
    .empty (item_empty),
    .pop   (item_pop)
  );

  // Parse one character per cycle while the result queue has room
  ttip_back u_back (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .in_empty (item_empty),
    .in_pop   (item_pop),
    .res      (res),
    .res_push (res_push),
    .res_full (res_full)
  );

  // Hold results for the consumer
  ttip_oq u_oq (
    .clk       (clk),
    .rst       (rst),
    .din       (res),
    .push      (res_push),
    .full      (res_full),
    .value     (value),
    .end_index (end_index),
    .bad_base  (bad_base),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

`default_nettype wire

@@ design/ttip_front.sv @@
`default_nettype none

module ttip_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [ttip_pkg::CH_W-1:0]     ch,
  input  logic                          first,
  input  logic [ttip_pkg::RADIX_W-1:0]  radix,
  input  logic                          push,
  output logic                          full,
  output ttip_pkg::item_t               item,
  output logic                          empty,
  input  logic                          pop
);

  ttip_pkg::item_t             cls;
  logic [ttip_pkg::CH_W-1:0]   ofs;
  ttip_pkg::item_t             mem [2];
  logic                        wp;
  logic                        rp;
  logic [1:0]                  cnt;
  logic                        do_push;
  logic                        do_pop;

  // Character classification
  always_comb begin
    cls          = '0;
    ofs          = '0;
    cls.first    = first;
    cls.radix    = radix;
    cls.bad_base = first && (radix == ttip_pkg::BASE_ONE || radix > ttip_pkg::BASE_MAX);
    cls.nul      = (ch == ttip_pkg::CH_NUL);
    cls.space    = ch inside {[ttip_pkg::CH_TAB:ttip_pkg::CH_CR], ttip_pkg::CH_SPACE};
    cls.sign     = (ch == ttip_pkg::CH_PLUS) || (ch == ttip_pkg::CH_MINUS);
    cls.minus    = (ch == ttip_pkg::CH_MINUS);
    cls.zero     = (ch == ttip_pkg::CH_ZERO);
    cls.is_x     = (ch == ttip_pkg::CH_LX) || (ch == ttip_pkg::CH_UX);
    if (ch inside {[ttip_pkg::CH_ZERO:ttip_pkg::CH_NINE]}) begin
      ofs         = ch - ttip_pkg::CH_ZERO;
      cls.dec     = 1'b1;
      cls.has_dig = 1'b1;
    end else if (ch inside {[ttip_pkg::CH_LA:ttip_pkg::CH_LZ]}) begin
      ofs         = ch - ttip_pkg::CH_LA + ttip_pkg::LETTER_OFS;
      cls.has_dig = 1'b1;
    end else if (ch inside {[ttip_pkg::CH_UA:ttip_pkg::CH_UZ]}) begin
      ofs         = ch - ttip_pkg::CH_UA + ttip_pkg::LETTER_OFS;
      cls.has_dig = 1'b1;
    end
    cls.dig = ofs[ttip_pkg::RADIX_W-1:0];
  end

  // Two-entry queue toward the back end
  assign full    = (cnt == 2'd2);
  assign empty   = (cnt == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign item    = mem[rp];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) begin
        wp <= ~wp;
      end
      if (do_pop) begin
        rp <= ~rp;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

@@ design/ttip_back.sv @@
`default_nettype none

module ttip_back (
  input  logic             clk,
  input  logic             rst,
  input  ttip_pkg::item_t  item,
  input  logic             in_empty,
  output logic             in_pop,
  output ttip_pkg::result_t res,
  output logic             res_push,
  input  logic             res_full
);

  // Parse state
  logic                           active;
  logic                           num_started;
  logic [1:0]                     sign_seen;
  logic [ttip_pkg::RADIX_W-1:0]   work_base;
  logic [ttip_pkg::VAL_W-1:0]     accum;
  logic [ttip_pkg::POS_W-1:0]     position;
  logic                           zero_pending;

  logic                           active_next;
  logic                           num_started_next;
  logic [1:0]                     sign_seen_next;
  logic [ttip_pkg::RADIX_W-1:0]   work_base_next;
  logic [ttip_pkg::VAL_W-1:0]     accum_next;
  logic [ttip_pkg::POS_W-1:0]     position_next;
  logic                           zero_pending_next;

  // State as seen by this item (a first item restarts it)
  logic                           s_act;
  logic                           s_in;
  logic [1:0]                     s_sign;
  logic [ttip_pkg::RADIX_W-1:0]   s_wb;
  logic [ttip_pkg::VAL_W-1:0]     s_acc;
  logic [ttip_pkg::POS_W-1:0]     s_pos;
  logic                           s_zp;

  logic [ttip_pkg::RADIX_W-1:0]   wb_e;
  logic                           in_e;
  logic [ttip_pkg::RADIX_W-1:0]   eff_b;
  logic                           dig_ok;
  logic [ttip_pkg::VAL_W-1:0]     prod;
  logic [ttip_pkg::VAL_W-1:0]     sum;
  logic [ttip_pkg::POS_W-1:0]     pos_inc;
  logic                           adv;
  logic                           emit;
  logic [ttip_pkg::POS_W-1:0]     endi;
  logic                           go;

  assign in_pop = !in_empty && !res_full;
  assign go     = in_pop;

  // Restart view
  always_comb begin
    s_act  = item.first ? 1'b1 : active;
    s_in   = item.first ? 1'b0 : num_started;
    s_sign = item.first ? ttip_pkg::SIGN_NONE : sign_seen;
    s_wb   = item.first ? item.radix : work_base;
    s_acc  = item.first ? '0 : accum;
    s_pos  = item.first ? '0 : position;
    s_zp   = item.first ? 1'b0 : zero_pending;
  end

  // Digit arithmetic; a pending zero leaves the accumulator at zero
  always_comb begin
    if (s_zp) begin
      wb_e = (s_wb == ttip_pkg::BASE_AUTO) ? ttip_pkg::BASE_OCT : s_wb;
    end else begin
      wb_e = s_wb;
    end
    in_e    = s_in || s_zp;
    eff_b   = (wb_e == ttip_pkg::BASE_AUTO && item.dec) ? ttip_pkg::BASE_DEC : wb_e;
    dig_ok  = item.has_dig && (item.dig < eff_b);
    prod    = s_acc * ttip_pkg::VAL_W'(eff_b);
    sum     = prod + ttip_pkg::VAL_W'(item.dig);
    pos_inc = s_pos + ttip_pkg::POS_W'(1);
  end

  // Character step
  always_comb begin
    active_next       = active;
    num_started_next  = num_started;
    sign_seen_next    = sign_seen;
    work_base_next    = work_base;
    accum_next        = accum;
    position_next     = position;
    zero_pending_next = zero_pending;
    res               = '0;
    res_push          = 1'b0;
    adv               = 1'b0;
    emit              = 1'b0;
    endi              = s_pos;

    if (item.bad_base) begin
      // Bad base: report at once and drop all parse state
      active_next       = 1'b0;
      num_started_next  = 1'b0;
      sign_seen_next    = ttip_pkg::SIGN_NONE;
      work_base_next    = '0;
      accum_next        = '0;
      position_next     = '0;
      zero_pending_next = 1'b0;
      res.bad_base      = 1'b1;
      res_push          = 1'b1;
    end else if (s_act) begin
      active_next       = 1'b1;
      num_started_next  = in_e;
      sign_seen_next    = s_sign;
      work_base_next    = wb_e;
      accum_next        = s_acc;
      position_next     = s_pos;
      zero_pending_next = 1'b0;

      if (s_zp && item.is_x) begin
        // 0x prefix
        work_base_next   = ttip_pkg::BASE_HEX;
        num_started_next = 1'b1;
        adv              = 1'b1;
      end else if (s_zp && s_pos >= ttip_pkg::MAX_POS) begin
        emit = 1'b1;
      end else if (item.nul) begin
        emit = 1'b1;
      end else if ((wb_e == ttip_pkg::BASE_AUTO || wb_e == ttip_pkg::BASE_HEX) &&
                   !in_e && item.zero) begin
        zero_pending_next = 1'b1;
        position_next     = pos_inc;
      end else if (!in_e && s_sign == ttip_pkg::SIGN_NONE && item.space) begin
        adv = 1'b1;
      end else if (!in_e && s_sign == ttip_pkg::SIGN_NONE && item.sign) begin
        sign_seen_next = item.minus ? ttip_pkg::SIGN_MINUS : ttip_pkg::SIGN_PLUS;
        adv            = 1'b1;
      end else if (dig_ok) begin
        num_started_next = 1'b1;
        work_base_next   = eff_b;
        accum_next       = sum;
        adv              = 1'b1;
      end else begin
        emit = 1'b1;
      end

      // Move past the character; stop at the length limit
      if (adv) begin
        position_next = pos_inc;
        if (pos_inc >= ttip_pkg::MAX_POS) begin
          emit = 1'b1;
          endi = pos_inc;
        end
      end

      if (emit) begin
        active_next       = 1'b0;
        zero_pending_next = 1'b0;
        res.mag           = accum_next;
        res.neg           = (sign_seen_next == ttip_pkg::SIGN_MINUS);
        res.end_index     = endi;
        res_push          = 1'b1;
      end
    end
    if (!go) begin
      res_push = 1'b0;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      num_started  <= 1'b0;
      sign_seen    <= ttip_pkg::SIGN_NONE;
      work_base    <= '0;
      accum        <= '0;
      position     <= '0;
      zero_pending <= 1'b0;
    end else if (go) begin
      active       <= active_next;
      num_started  <= num_started_next;
      sign_seen    <= sign_seen_next;
      work_base    <= work_base_next;
      accum        <= accum_next;
      position     <= position_next;
      zero_pending <= zero_pending_next;
    end
  end

endmodule

`default_nettype wire

@@ design/ttip_oq.sv @@
`default_nettype none

module ttip_oq (
  input  logic                               clk,
  input  logic                               rst,
  input  ttip_pkg::result_t                  din,
  input  logic                               push,
  output logic                               full,
  output logic signed [ttip_pkg::VAL_W-1:0]  value,
  output logic        [ttip_pkg::POS_W-1:0]  end_index,
  output logic                               bad_base,
  output logic                               empty,
  input  logic                               pop
);

  ttip_pkg::result_t  mem [2];
  ttip_pkg::result_t  head;
  logic               wp;
  logic               rp;
  logic [1:0]         cnt;
  logic               do_push;
  logic               do_pop;

  assign full    = (cnt == 2'd2);
  assign empty   = (cnt == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rp];

  // Apply the sign on the way out
  assign value     = head.neg ? -$signed(head.mag) : $signed(head.mag);
  assign end_index = head.end_index;
  assign bad_base  = head.bad_base;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) begin
        wp <= ~wp;
      end
      if (do_pop) begin
        rp <= ~rp;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

@@ design/ttip_chk.sv @@
`default_nettype none
`include "assert_macros.svh"

module ttip_chk (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               full,
  input  logic signed [ttip_pkg::VAL_W-1:0]  value,
  input  logic        [ttip_pkg::POS_W-1:0]  end_index,
  input  logic                               bad_base,
  input  logic                               empty,
  input  logic                               pop
);

  // Reset leaves both queues empty
  `CHK_RST(a_rst_clear, rst, empty && !full)

  // A waiting result holds until its transfer
  `CHK_NXT(a_res_hold, !empty && !pop, !empty && $stable(value) && $stable(end_index) && $stable(bad_base))

  // A bad-base report carries a zero value at index zero
  `CHK_IMP(a_bad_zero, !empty && bad_base, value == 0 && end_index == 0)

  // Parsing never stops past the limit lookahead
  `CHK_IMP(a_end_max, !empty, end_index <= ttip_pkg::POS_W'(ttip_pkg::MAX_CHARS + 1))

endmodule

bind text_to_integer_parser_top ttip_chk u_chk (.*);

`default_nettype wire
